// ----- rtl/flpr_pkg.sv -----
// Shared types, constants and the CRC-8 step for the framed link parser/router.
// No dependencies; the RTL files that use it refer to it by scoped names, the testbench imports it.
package flpr_pkg;

   localparam int MAX_PAYLOAD  = 16;
   localparam int STREAM_COUNT = 2;
   localparam int STORE_DEPTH  = STREAM_COUNT * MAX_PAYLOAD;
   localparam int STORE_AW     = $clog2(STORE_DEPTH);
   localparam int PCNT_W       = $clog2(MAX_PAYLOAD + 1);
   localparam int CSR_IDX_W    = 3;

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_INIT = 8'h00;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_STRAY   = 3'd1;
   localparam logic [2:0] ST_LENGTH  = 3'd2;
   localparam logic [2:0] ST_BAD_CRC = 3'd3;
   localparam logic [2:0] ST_BAD_END = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWNSTRM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UPSTRM    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BROADCAST = 3'd5;

   localparam logic [7:0] RST_START     = 8'd2;
   localparam logic [7:0] RST_END       = 8'd3;
   localparam logic [7:0] RST_OWN       = 8'd1;
   localparam logic [7:0] RST_DOWNSTRM  = 8'd2;
   localparam logic [7:0] RST_UPSTRM    = 8'd0;
   localparam logic [7:0] RST_BROADCAST = 8'd255;

   typedef struct packed {
      logic       from_stream;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        source_link;
      logic [7:0]  dest_addr;
      logic [7:0]  sender_addr;
      logic [7:0]  command_code;
      logic [4:0]  payload_length;
      logic [7:0]  payload_value;
      logic        last;
      logic        deliver_local;
      logic        forward_other;
      logic        unknown_dest;
      logic [15:0] error_total;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic take;       // input byte accepted this cycle
      logic load_err;   // load error item into output register
      logic load_item;  // load frame item from store read data
      logic advance;    // step replay index
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic byte_err;
      logic byte_frame;
      logic item_last;
   } dp_stat_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
      end
      return v;
   endfunction

endpackage

// ----- rtl/framed_link_parser_router_core.sv -----
// Framed link parser/router, two byte links (0 upstream host, 1 downstream slave).
// req_: one received byte per item, tagged with its link. rsp_: result items.
// csr_: write-only config (start/end byte, own, downstream, upstream, broadcast).
// A byte that neither completes a frame nor breaks it is taken and yields
// nothing. A protocol error (stray byte, length overflow, bad CRC,
// bad end byte) yields one item, valid the cycle after the byte is taken.
// A good frame's end byte yields max(len,1) items, one per stored payload byte;
// each item goes from a payload store read into the output register, and
// the input is held for the whole replay, receiver stalls included.
// req_stall is high from the end byte until the last item is taken; while the
// receiver holds rsp_stall, the shown item waits unchanged in its register.
// Reset (synchronous) returns both parsers to waiting for a start byte, clears
// the error count and loads the register defaults. The payload store needs no
// clearing: every entry read was written earlier in the same frame.
// Depends on flpr_pkg, flpr_ctrl, flpr_dp, flpr_ram.
module framed_link_parser_router_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  flpr_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output flpr_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [flpr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_wdata
);

   flpr_pkg::dp_cmd_type  cmd;
   flpr_pkg::dp_stat_type stat;

   flpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   flpr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/flpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module flpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/flpr_ctrl.sv -----
// Controller: sequences byte intake, error items and frame replay.
// Depends on flpr_pkg for the command and status structs.
module flpr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  rsp_stall,
   input  flpr_pkg::dp_stat_type stat,
   output flpr_pkg::dp_cmd_type  cmd,
   output logic                  req_stall,
   output logic                  rsp_valid
);

   typedef enum logic [1:0] {S_IDLE, S_FETCH, S_SHOW} state_type;

   state_type state_ff;
   logic      req_stall_ff;
   logic      rsp_valid_ff;
   logic      take;

   assign take = (state_ff == S_IDLE) && req_valid && !req_stall_ff;

   always_comb begin
      cmd           = '0;
      cmd.take      = take;
      cmd.load_err  = take && stat.byte_err;
      cmd.load_item = (state_ff == S_FETCH);
      cmd.advance   = (state_ff == S_SHOW) && !rsp_stall && !stat.item_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (take && stat.byte_err) begin
                  state_ff     <= S_SHOW;
                  req_stall_ff <= 1'b1;
                  rsp_valid_ff <= 1'b1;
               end else if (take && stat.byte_frame) begin
                  state_ff     <= S_FETCH;
                  req_stall_ff <= 1'b1;
               end
            end
            S_FETCH: begin
               // store read data is valid now
               state_ff     <= S_SHOW;
               rsp_valid_ff <= 1'b1;
            end
            S_SHOW: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (stat.item_last) begin
                     state_ff     <= S_IDLE;
                     req_stall_ff <= 1'b0;
                  end else begin
                     state_ff <= S_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/flpr_dp.sv -----
// Datapath: per-link frame parsers, running CRC, payload store, routing,
// error counter, config registers and the output item register.
// Depends on flpr_pkg and flpr_ram.
module flpr_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  flpr_pkg::req_type                req_data,
   input  logic                             csr_we,
   input  logic [flpr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                       csr_wdata,
   input  flpr_pkg::dp_cmd_type             cmd,
   output flpr_pkg::dp_stat_type            stat,
   output flpr_pkg::rsp_type                rsp_data
);

   localparam int PW = flpr_pkg::PCNT_W;
   localparam int AW = flpr_pkg::STORE_AW;
   localparam int NS = flpr_pkg::STREAM_COUNT;

   typedef enum logic [2:0] {
      PH_IDLE, PH_DST, PH_SRC, PH_CMD, PH_LEN, PH_PAY, PH_CRC, PH_END
   } phase_type;

   // config
   logic [7:0] start_ff, end_ff, own_ff, down_ff, up_ff, bcast_ff;

   // per-link parser state
   phase_type     phase_ff [NS];
   logic [7:0]    dest_ff  [NS];
   logic [7:0]    sender_ff[NS];
   logic [7:0]    cmd_ff   [NS];
   logic [PW-1:0] len_ff   [NS];
   logic [PW-1:0] cnt_ff   [NS];
   logic [7:0]    crc_ff   [NS];
   logic [15:0]   err_cnt_ff, err_cnt_in;

   phase_type     ph_in;
   logic [7:0]    dest_in, sender_in, cmd_in, crc_in, crc_upd;
   logic [PW-1:0] len_in, cnt_in, cnt_inc;

   logic          s;
   logic [7:0]    b;
   logic          err, frame;
   logic [2:0]    err_code;

   // routing
   logic [7:0]    dst, far_addr;
   logic          loc, fwd, unk;

   // replay
   logic          rep_s_ff, rep_s_in;
   logic [7:0]    rep_dst_ff, rep_sender_ff, rep_cmd_ff;
   logic [PW-1:0] rep_len_ff, rep_n_ff, k_ff, k_in, k_next;
   logic          rep_loc_ff, rep_fwd_ff, rep_unk_ff;

   // store
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    rd_data;

   flpr_pkg::rsp_type rsp_ff, err_item, frame_item;

   assign s = req_data.from_stream;
   assign b = req_data.data_byte;

   assign crc_upd = flpr_pkg::crc8_update(crc_ff[s], b);
   assign cnt_inc = cnt_ff[s] + PW'(1);

   always_comb begin
      ph_in     = phase_ff[s];
      dest_in   = dest_ff[s];
      sender_in = sender_ff[s];
      cmd_in    = cmd_ff[s];
      len_in    = len_ff[s];
      cnt_in    = cnt_ff[s];
      crc_in    = crc_ff[s];
      err       = 1'b0;
      err_code  = flpr_pkg::ST_OK;
      frame     = 1'b0;
      wr_en     = 1'b0;
      unique case (phase_ff[s])
         PH_IDLE: begin
            if (b == start_ff) begin
               ph_in  = PH_DST;
               crc_in = flpr_pkg::CRC_INIT;
               cnt_in = '0;
            end else begin
               err      = 1'b1;
               err_code = flpr_pkg::ST_STRAY;
            end
         end
         PH_DST: begin
            dest_in = b;
            crc_in  = crc_upd;
            ph_in   = PH_SRC;
         end
         PH_SRC: begin
            sender_in = b;
            crc_in    = crc_upd;
            ph_in     = PH_CMD;
         end
         PH_CMD: begin
            cmd_in = b;
            crc_in = crc_upd;
            ph_in  = PH_LEN;
         end
         PH_LEN: begin
            cnt_in = '0;
            if (b > 8'(flpr_pkg::MAX_PAYLOAD)) begin
               ph_in    = PH_IDLE;
               err      = 1'b1;
               err_code = flpr_pkg::ST_LENGTH;
            end else begin
               len_in = b[PW-1:0];
               crc_in = crc_upd;
               ph_in  = (b == 8'd0) ? PH_CRC : PH_PAY;
            end
         end
         PH_PAY: begin
            wr_en  = cmd.take;
            cnt_in = cnt_inc;
            crc_in = crc_upd;
            if (cnt_inc >= len_ff[s]) begin
               ph_in = PH_CRC;
            end
         end
         PH_CRC: begin
            if (b == crc_ff[s]) begin
               ph_in = PH_END;
            end else begin
               ph_in    = PH_IDLE;
               cnt_in   = '0;
               err      = 1'b1;
               err_code = flpr_pkg::ST_BAD_CRC;
            end
         end
         default: begin
            // end byte
            ph_in  = PH_IDLE;
            cnt_in = '0;
            if (b != end_ff) begin
               err      = 1'b1;
               err_code = flpr_pkg::ST_BAD_END;
            end else begin
               frame = 1'b1;
            end
         end
      endcase
   end

   assign dst      = dest_ff[s];
   assign far_addr = s ? up_ff : down_ff;
   assign loc      = (dst == own_ff) || (dst == bcast_ff);
   assign fwd      = (dst == far_addr) || (dst == bcast_ff);
   assign unk      = !loc && !fwd;

   // unknown destination counts once, before the frame items
   assign err_cnt_in = err_cnt_ff + 16'(cmd.take && (err || (frame && unk)));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            phase_ff[i]  <= PH_IDLE;
            dest_ff[i]   <= '0;
            sender_ff[i] <= '0;
            cmd_ff[i]    <= '0;
            len_ff[i]    <= '0;
            cnt_ff[i]    <= '0;
            crc_ff[i]    <= '0;
         end
         err_cnt_ff <= '0;
         k_ff       <= '0;
         start_ff   <= flpr_pkg::RST_START;
         end_ff     <= flpr_pkg::RST_END;
         own_ff     <= flpr_pkg::RST_OWN;
         down_ff    <= flpr_pkg::RST_DOWNSTRM;
         up_ff      <= flpr_pkg::RST_UPSTRM;
         bcast_ff   <= flpr_pkg::RST_BROADCAST;
      end else begin
         if (cmd.take) begin
            phase_ff[s]  <= ph_in;
            dest_ff[s]   <= dest_in;
            sender_ff[s] <= sender_in;
            cmd_ff[s]    <= cmd_in;
            len_ff[s]    <= len_in;
            cnt_ff[s]    <= cnt_in;
            crc_ff[s]    <= crc_in;
         end
         err_cnt_ff <= err_cnt_in;
         k_ff       <= k_in;
         if (csr_we) begin
            unique case (csr_index)
               flpr_pkg::CSR_START:     start_ff <= csr_wdata;
               flpr_pkg::CSR_END:       end_ff   <= csr_wdata;
               flpr_pkg::CSR_OWN:       own_ff   <= csr_wdata;
               flpr_pkg::CSR_DOWNSTRM:  down_ff  <= csr_wdata;
               flpr_pkg::CSR_UPSTRM:    up_ff    <= csr_wdata;
               flpr_pkg::CSR_BROADCAST: bcast_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // replay of a good frame: item k reads store entry k of the frame's link
   assign k_next   = k_ff + PW'(1);
   assign k_in     = (cmd.take && frame) ? '0 : (cmd.advance ? k_next : k_ff);
   assign rep_s_in = (cmd.take && frame) ? s : rep_s_ff;
   assign rd_addr  = (rep_s_in ? AW'(flpr_pkg::MAX_PAYLOAD) : AW'(0)) + AW'(k_in);
   assign wr_addr  = (s ? AW'(flpr_pkg::MAX_PAYLOAD) : AW'(0)) + AW'(cnt_ff[s]);

   always_ff @(posedge clock) begin
      rep_s_ff <= rep_s_in;
      if (cmd.take && frame) begin
         rep_dst_ff    <= dst;
         rep_sender_ff <= (!s && fwd) ? own_ff : sender_ff[s];
         rep_cmd_ff    <= cmd_ff[s];
         rep_len_ff    <= len_ff[s];
         rep_n_ff      <= (len_ff[s] == '0) ? PW'(1) : len_ff[s];
         rep_loc_ff    <= loc;
         rep_fwd_ff    <= fwd;
         rep_unk_ff    <= unk;
      end
      if (cmd.load_err) begin
         rsp_ff <= err_item;
      end else if (cmd.load_item) begin
         rsp_ff <= frame_item;
      end
   end

   always_comb begin
      err_item             = '0;
      err_item.status      = err_code;
      err_item.source_link = s;
      err_item.last        = 1'b1;
      err_item.error_total = err_cnt_in;

      frame_item.status         = flpr_pkg::ST_OK;
      frame_item.source_link    = rep_s_ff;
      frame_item.dest_addr      = rep_dst_ff;
      frame_item.sender_addr    = rep_sender_ff;
      frame_item.command_code   = rep_cmd_ff;
      frame_item.payload_length = 5'(rep_len_ff);
      frame_item.payload_value  = (rep_len_ff == '0) ? 8'd0 : rd_data;
      frame_item.last           = (k_next == rep_n_ff);
      frame_item.deliver_local  = rep_loc_ff;
      frame_item.forward_other  = rep_fwd_ff;
      frame_item.unknown_dest   = rep_unk_ff;
      frame_item.error_total    = err_cnt_ff;
   end

   flpr_ram #(
      .WIDTH (8),
      .DEPTH (flpr_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (b),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      stat            = '0;
      stat.byte_err   = err;
      stat.byte_frame = frame;
      stat.item_last  = rsp_ff.last;
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/flpr_chk.sv -----
// Port-level checks for the framed link parser/router, bound to the top level.
// Depends on flpr_pkg and framed_link_parser_router_core.
module flpr_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input flpr_pkg::rsp_type rsp_data
);

   // no byte is taken while an item is on offer
   a_no_take_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result item waits");

   // a run that is not finished keeps the input closed
   a_run_holds_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last) |=> req_stall)
      else $error("input opened in the middle of a frame replay");

   // error items stand alone with zeroed frame fields
   a_error_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != flpr_pkg::ST_OK) |->
         (rsp_data.last && rsp_data.dest_addr == 8'd0 && rsp_data.payload_length == 5'd0))
      else $error("malformed error item");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result item changed");

endmodule

bind framed_link_parser_router_core flpr_chk u_flpr_chk (.*);

// ----- sim/framed_link_parser_router_core_tb.sv -----
// Self-checking testbench for framed_link_parser_router_core: drives byte items on both
// links, predicts every result item with its own parser/router model and checks them.
// Depends on flpr_pkg and the core RTL only.
module framed_link_parser_router_core_tb;
   import flpr_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 2 * MAX_PAYLOAD + 8;
   localparam int HOLD_CYCLES    = 300;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum logic [2:0] {
      P_IDLE, P_DST, P_SRC, P_CMD, P_LEN, P_PAY, P_CRC, P_END
   } parse_phase_type;

   typedef enum logic [1:0] {
      FRM_GOOD, FRM_BAD_CRC, FRM_BAD_END, FRM_BAD_LEN
   } frame_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;

   framed_link_parser_router_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // register copies
   logic [7:0] reg_start, reg_end, reg_own, reg_down, reg_up, reg_bcast;
   // per-link parser state
   parse_phase_type phase_of [2];
   logic [7:0]   dest_of [2];
   logic [7:0]   sender_of [2];
   logic [7:0]   cmd_of [2];
   logic [7:0]   crc_of [2];
   logic [4:0]   len_of [2];
   logic [4:0]   count_of [2];
   logic [7:0]   payload_mem [2][MAX_PAYLOAD];
   logic [15:0]  err_total;

   rsp_type expected_results [$];
   req_type frame_bytes [$];

   int   idle_pct = 0;
   int   stall_pct = 0;
   logic start_hold = 1'b0;
   int   hold_left = 0;
   int   fail_count = 0;
   int   items_sent = 0;
   int   results_checked = 0;
   int   good_frames = 0;
   int   error_results = 0;
   int   quiet_cycles = 0;

   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] v;
      v = acc ^ b;
      repeat (8) v = (v << 1) ^ (v[7] ? CRC_POLY : 8'h00);
      return v;
   endfunction

   function automatic req_type make_item(input logic s, input logic [7:0] b);
      req_type it;
      it.from_stream = s;
      it.data_byte   = b;
      return it;
   endfunction

   function automatic void reset_model();
      reg_start = RST_START;
      reg_end   = RST_END;
      reg_own   = RST_OWN;
      reg_down  = RST_DOWNSTRM;
      reg_up    = RST_UPSTRM;
      reg_bcast = RST_BROADCAST;
      for (int s = 0; s < 2; s++) begin
         phase_of[s]  = P_IDLE;
         dest_of[s]   = '0;
         sender_of[s] = '0;
         cmd_of[s]    = '0;
         crc_of[s]    = '0;
         len_of[s]    = '0;
         count_of[s]  = '0;
      end
      err_total = '0;
   endfunction

   function automatic void push_error(input logic s, input logic [2:0] code);
      rsp_type r;
      err_total = err_total + 16'd1;
      r = '0;
      r.status      = code;
      r.source_link = s;
      r.last        = 1'b1;
      r.error_total = err_total;
      expected_results.push_back(r);
   endfunction

   function automatic void queue_frame_items(input logic s);
      rsp_type    r;
      logic [7:0] far_addr;
      logic       hit_local, fwd, unk;
      int         n;
      far_addr  = s ? reg_up : reg_down;
      hit_local = (dest_of[s] == reg_own) || (dest_of[s] == reg_bcast);
      fwd       = (dest_of[s] == far_addr) || (dest_of[s] == reg_bcast);
      unk       = !hit_local && !fwd;
      if (unk) err_total = err_total + 16'd1;
      n = (len_of[s] == 0) ? 1 : int'(len_of[s]);
      for (int k = 0; k < n; k++) begin
         r = '0;
         r.status         = ST_OK;
         r.source_link    = s;
         r.dest_addr      = dest_of[s];
         // frames from the host that go downstream carry our own address as source
         r.sender_addr    = (!s && fwd) ? reg_own : sender_of[s];
         r.command_code   = cmd_of[s];
         r.payload_length = len_of[s];
         r.payload_value  = (len_of[s] == 0) ? 8'h00 : payload_mem[s][k];
         r.last           = (k == n - 1);
         r.deliver_local  = hit_local;
         r.forward_other  = fwd;
         r.unknown_dest   = unk;
         r.error_total    = err_total;
         expected_results.push_back(r);
      end
   endfunction

   function automatic void absorb_byte(input logic s, input logic [7:0] b);
      case (phase_of[s])
         P_IDLE: begin
            if (b == reg_start) begin
               phase_of[s] = P_DST;
               crc_of[s]   = '0;
               count_of[s] = '0;
            end else begin
               push_error(s, ST_STRAY);
            end
         end
         P_DST: begin
            dest_of[s]  = b;
            crc_of[s]   = crc8_step(crc_of[s], b);
            phase_of[s] = P_SRC;
         end
         P_SRC: begin
            sender_of[s] = b;
            crc_of[s]    = crc8_step(crc_of[s], b);
            phase_of[s]  = P_CMD;
         end
         P_CMD: begin
            cmd_of[s]   = b;
            crc_of[s]   = crc8_step(crc_of[s], b);
            phase_of[s] = P_LEN;
         end
         P_LEN: begin
            if (b > MAX_PAYLOAD) begin
               phase_of[s] = P_IDLE;
               count_of[s] = '0;
               push_error(s, ST_LENGTH);
            end else begin
               len_of[s]   = b[4:0];
               count_of[s] = '0;
               crc_of[s]   = crc8_step(crc_of[s], b);
               phase_of[s] = (b == 0) ? P_CRC : P_PAY;
            end
         end
         P_PAY: begin
            payload_mem[s][count_of[s]] = b;
            count_of[s] = count_of[s] + 5'd1;
            crc_of[s]   = crc8_step(crc_of[s], b);
            if (count_of[s] >= len_of[s]) phase_of[s] = P_CRC;
         end
         P_CRC: begin
            if (b == crc_of[s]) begin
               phase_of[s] = P_END;
            end else begin
               phase_of[s] = P_IDLE;
               count_of[s] = '0;
               push_error(s, ST_BAD_CRC);
            end
         end
         default: begin
            phase_of[s] = P_IDLE;
            count_of[s] = '0;
            if (b != reg_end) push_error(s, ST_BAD_END);
            else queue_frame_items(s);
         end
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      fail_count++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %h want %h",
                                   results_checked, name, got, want));
   endtask

   task automatic check_result(input rsp_type got, input rsp_type want);
      compare_field("status", 16'(got.status), 16'(want.status));
      compare_field("source_link", 16'(got.source_link), 16'(want.source_link));
      compare_field("dest_addr", 16'(got.dest_addr), 16'(want.dest_addr));
      compare_field("sender_addr", 16'(got.sender_addr), 16'(want.sender_addr));
      compare_field("command_code", 16'(got.command_code), 16'(want.command_code));
      compare_field("payload_length", 16'(got.payload_length), 16'(want.payload_length));
      compare_field("payload_value", 16'(got.payload_value), 16'(want.payload_value));
      compare_field("last", 16'(got.last), 16'(want.last));
      compare_field("deliver_local", 16'(got.deliver_local), 16'(want.deliver_local));
      compare_field("forward_other", 16'(got.forward_other), 16'(want.forward_other));
      compare_field("unknown_dest", 16'(got.unknown_dest), 16'(want.unknown_dest));
      compare_field("error_total", got.error_total, want.error_total);
   endtask

   // predicts on accepted bytes, checks accepted result items
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) absorb_byte(req_data.from_stream, req_data.data_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: %h", rsp_data));
            end else begin
               want = expected_results.pop_front();
               check_result(rsp_data, want);
               if (want.status != ST_OK) error_results++;
               else if (want.last) good_frames++;
            end
            results_checked++;
         end
      end
   end

   // receiver: random stall plus an optional long hold-off
   always @(posedge clock) begin
      if (start_hold) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      rsp_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d results pending",
                  quiet_cycles, expected_results.size());
         $display("[framed_link_parser_router_core] ERROR");
         $finish;
      end
   end

   task automatic send_item(input req_type it);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_plan();
      while (frame_bytes.size() != 0) send_item(frame_bytes.pop_front());
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      // first let the last accepted byte be predicted
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_START:     reg_start = val;
         CSR_END:       reg_end   = val;
         CSR_OWN:       reg_own   = val;
         CSR_DOWNSTRM:  reg_down  = val;
         CSR_UPSTRM:    reg_up    = val;
         CSR_BROADCAST: reg_bcast = val;
         default: ;
      endcase
   endtask

   // writes every register, plus the two unused indexes which must be ignored
   task automatic set_config(input logic [7:0] start_v, input logic [7:0] end_v,
                             input logic [7:0] own_v, input logic [7:0] down_v,
                             input logic [7:0] up_v, input logic [7:0] bcast_v);
      wait_for_results();
      write_reg(CSR_START, start_v);
      write_reg(CSR_SPARE_LO, 8'($urandom));
      write_reg(CSR_END, end_v);
      write_reg(CSR_OWN, own_v);
      write_reg(CSR_DOWNSTRM, down_v);
      write_reg(CSR_UPSTRM, up_v);
      write_reg(CSR_BROADCAST, bcast_v);
      write_reg(CSR_SPARE_HI, 8'($urandom));
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] pick_payload();
      int r;
      r = $urandom_range(5);
      // start and end byte values inside the payload are plain data
      if (r == 0) return reg_start;
      if (r == 1) return reg_end;
      return 8'($urandom);
   endfunction

   task automatic build_frame(input logic s, input logic [7:0] dst, input int len,
                              input frame_mode_type mode);
      logic [7:0] acc, src, cmd, b, flip;
      src  = 8'($urandom);
      cmd  = 8'($urandom);
      flip = 8'($urandom_range(255, 1));
      frame_bytes.push_back(make_item(s, reg_start));
      frame_bytes.push_back(make_item(s, dst));
      frame_bytes.push_back(make_item(s, src));
      frame_bytes.push_back(make_item(s, cmd));
      frame_bytes.push_back(make_item(s, 8'(len)));
      if (mode == FRM_BAD_LEN) return;
      acc = crc8_step(crc8_step(crc8_step(crc8_step(CRC_INIT, dst), src), cmd), 8'(len));
      for (int i = 0; i < len; i++) begin
         b = pick_payload();
         acc = crc8_step(acc, b);
         frame_bytes.push_back(make_item(s, b));
      end
      frame_bytes.push_back(make_item(s, (mode == FRM_BAD_CRC) ? acc ^ flip : acc));
      frame_bytes.push_back(make_item(s, (mode == FRM_BAD_END) ? reg_end ^ flip : reg_end));
   endtask

   // sends two frames on opposite links with their bytes interleaved at random
   task automatic send_pair(input logic [7:0] dst_a, input int len_a,
                            input frame_mode_type mode_a,
                            input logic [7:0] dst_b, input int len_b,
                            input frame_mode_type mode_b,
                            input logic link_a);
      req_type plan_a [$];
      req_type plan_b [$];
      build_frame(link_a, dst_a, len_a, mode_a);
      plan_a = frame_bytes;
      frame_bytes.delete();
      build_frame(!link_a, dst_b, len_b, mode_b);
      plan_b = frame_bytes;
      frame_bytes.delete();
      while (plan_a.size() != 0 || plan_b.size() != 0) begin
         if (plan_b.size() == 0 || (plan_a.size() != 0 && $urandom_range(1) == 1))
            send_item(plan_a.pop_front());
         else
            send_item(plan_b.pop_front());
      end
   endtask

   function automatic logic [7:0] pick_dest();
      case ($urandom_range(4))
         0: return reg_own;
         1: return reg_down;
         2: return reg_up;
         3: return reg_bcast;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic int pick_length(input frame_mode_type mode);
      int r;
      r = $urandom_range(99);
      if (mode == FRM_BAD_LEN) return $urandom_range(255, MAX_PAYLOAD + 1);
      if (r < 65) return $urandom_range(4);
      if (r < 90) return $urandom_range(MAX_PAYLOAD - 1, 5);
      return MAX_PAYLOAD;
   endfunction

   function automatic frame_mode_type pick_mode();
      int r;
      r = $urandom_range(99);
      if (r < 76) return FRM_GOOD;
      if (r < 87) return FRM_BAD_CRC;
      if (r < 94) return FRM_BAD_END;
      return FRM_BAD_LEN;
   endfunction

   task automatic random_burst();
      frame_mode_type mode_a, mode_b;
      logic           link;
      int             r;
      r      = $urandom_range(99);
      link   = 1'($urandom_range(1));
      mode_a = pick_mode();
      mode_b = pick_mode();
      if (r < 6) begin
         send_item(make_item(link, 8'($urandom)));
      end else if (r < 36) begin
         send_pair(pick_dest(), pick_length(mode_a), mode_a,
                   pick_dest(), pick_length(mode_b), mode_b, link);
      end else begin
         build_frame(link, pick_dest(), pick_length(mode_a), mode_a);
         send_plan();
      end
   endtask

   task automatic test_good_frames();
      build_frame(1'b0, reg_own, 0, FRM_GOOD);
      build_frame(1'b1, reg_up, MAX_PAYLOAD, FRM_GOOD);
      build_frame(1'b0, reg_down, 3, FRM_GOOD);
      build_frame(1'b1, reg_bcast, 1, FRM_GOOD);
      send_plan();
      wait_for_results();
   endtask

   task automatic test_protocol_errors();
      send_item(make_item(1'b0, reg_start ^ 8'h01));
      send_item(make_item(1'b1, ~reg_start));
      build_frame(1'b0, reg_own, MAX_PAYLOAD + 1, FRM_BAD_LEN);
      build_frame(1'b1, reg_own, 255, FRM_BAD_LEN);
      build_frame(1'b0, reg_bcast, 2, FRM_BAD_CRC);
      build_frame(1'b1, reg_up, 0, FRM_BAD_END);
      send_plan();
      wait_for_results();
   endtask

   task automatic test_unknown_dest();
      logic [7:0] d;
      do d = 8'($urandom); while (d == reg_own || d == reg_down || d == reg_bcast);
      build_frame(1'b0, d, 2, FRM_GOOD);
      // the downstream address is unknown when seen from the slave link
      build_frame(1'b1, reg_down, 1, FRM_GOOD);
      send_plan();
      wait_for_results();
   endtask

   task automatic test_interleaved_links();
      send_pair(reg_down, 4, FRM_GOOD, reg_up, 5, FRM_GOOD, 1'b0);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      start_hold <= 1'b1;
      @(posedge clock);
      start_hold <= 1'b0;
      for (int i = 0; i < 2; i++) build_frame(i[0], reg_bcast, 4, FRM_GOOD);
      send_plan();
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int idle, input int stall, input int budget);
      int first;
      idle_pct  = idle;
      stall_pct = stall;
      first     = items_sent;
      while (items_sent - first < budget) random_burst();
      wait_for_results();
   endtask

   initial begin
      reset_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_good_frames();
      test_protocol_errors();
      test_unknown_dest();
      test_interleaved_links();
      test_backpressure();

      test_random_traffic(0, 0, 10);
      set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom));
      test_random_traffic(59, 0, 10);
      set_config(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
      test_random_traffic(0, 59, 10);
      set_config(8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00);
      test_random_traffic(24, 24, 10);

      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      $display("ran %0d bytes over both links, checked %0d result items", items_sent,
               results_checked);
      $display("good frames %0d, error items %0d, long receiver hold, four config sets",
               good_frames, error_results);
      if (fail_count == 0)
         $display("[framed_link_parser_router_core] OK");
      else
         $display("[framed_link_parser_router_core] ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/flpr_pkg.sv
rtl/flpr_ram.sv
rtl/flpr_ctrl.sv
rtl/flpr_dp.sv
rtl/framed_link_parser_router_core.sv
rtl/flpr_chk.sv
sim/framed_link_parser_router_core_tb.sv
